/* hdl/ffba_pkg.sv */
// shared constants, codes and types for the first-fit block allocator
package ffba_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int SIZE_W        = 24;
    localparam int STATUS_W      = 3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HEAP_LIMIT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd4;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // configuration register indexes
    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_HEAP_END   = 1'b1;

    // request broadcast to every cell
    typedef struct packed {
        logic              eval;
        logic              commit_reuse;
        logic              commit_free;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] new_base;
    } cell_ctl_t;

    // priority chain passed from newer cell to older cell
    typedef struct packed {
        logic              fit_seen;
        logic [ADDR_W-1:0] fit_addr;
        logic              base_seen;
        logic              base_used;
    } cell_chain_t;

endpackage

/* hdl/ffba_cell.sv */
// one table entry with its compare logic and its link in the priority chain
module ffba_cell
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctl_t   ctl,
    input  logic        entry_valid,
    input  logic        append,
    input  cell_chain_t chain_in,
    output cell_chain_t chain_out
);

    logic              used_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] length_reg;
    logic              hit_fit_reg;
    logic              hit_base_reg;
    logic              fit_claim;
    logic              base_claim;

    // compare results, registered while the state machine is in its eval state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_fit_reg  <= 1'b0;
            hit_base_reg <= 1'b0;
        end
        else if (ctl.eval)
        begin
            hit_fit_reg  <= entry_valid && !used_reg && (length_reg >= ctl.size);
            hit_base_reg <= entry_valid && (base_reg == ctl.addr);
        end
    end

    // newest hit wins: claim only if no newer cell has hit
    assign fit_claim  = hit_fit_reg && !chain_in.fit_seen;
    assign base_claim = hit_base_reg && !chain_in.base_seen;

    always_comb
    begin
        chain_out.fit_seen  = chain_in.fit_seen || hit_fit_reg;
        chain_out.fit_addr  = fit_claim ? base_reg : chain_in.fit_addr;
        chain_out.base_seen = chain_in.base_seen || hit_base_reg;
        chain_out.base_used = base_claim ? used_reg : chain_in.base_used;
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            used_reg   <= 1'b1;
            base_reg   <= ctl.new_base;
            length_reg <= ctl.size;
        end
        else if (ctl.commit_reuse && fit_claim)
        begin
            used_reg <= 1'b1;
        end
        else if (ctl.commit_free && base_claim)
        begin
            used_reg <= 1'b0;
        end
    end

endmodule

/* hdl/first_fit_block_allocator.sv */
// first-fit block allocator top level: request control, heap top and the cell row
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | cmd, req_size, req_addr
//  out     | output    | out_valid / out_ready| block_addr, reused, status
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// a request passes the eval state, for the parallel compare in every cell, and then
// the resolve state, for the ripple through the priority chain and the table update.
// a new request can be taken in the resolve state of the one before while out words are taken in time.
// a finished word waits in the output register; the next request is taken
// meanwhile and holds in its resolve cycle until the output register frees.
// reset clears the entry count, the heap top and heap_start, and sets heap_end to all ones.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [SIZE_W-1:0]   req_size,
    input  logic [ADDR_W-1:0]   req_addr,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   block_addr,
    output logic                reused,
    output logic [STATUS_W-1:0] status,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [ADDR_W-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_RESOLVE
    } state_t;

    state_t              state_reg,      state_next;
    logic                cmd_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic [ADDR_W-1:0]   heap_top_reg,   heap_top_next;
    logic [ADDR_W-1:0]   heap_start_reg, heap_end_reg;
    logic                out_valid_reg,  out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg,   out_addr_next;
    logic                out_reused_reg, out_reused_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                    in_accept;
    logic                    out_free;
    logic                    resolve_go;
    logic                    do_append;
    logic                    table_full;
    logic [ADDR_W:0]         new_top;
    logic                    over_limit;
    cell_ctl_t               ctl;
    cell_chain_t             chain_w [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] entry_valid;
    logic [TABLE_ENTRIES-1:0] append_sel;

    // handshake
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE) || ((state_reg == S_RESOLVE) && out_free);
    assign in_accept  = in_valid && in_ready;
    assign resolve_go = (state_reg == S_RESOLVE) && out_free;

    // heap growth check for an append
    assign table_full = (count_reg >= CNT_W'(TABLE_ENTRIES));
    assign new_top    = {1'b0, heap_top_reg} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, size_reg};
    assign over_limit = (new_top > {1'b0, heap_end_reg});

    // append when nothing fits and there is room
    assign do_append = resolve_go && (cmd_reg == CMD_ALLOC) && !chain_w[0].fit_seen
                       && !table_full && !over_limit;

    // broadcast to the cells
    always_comb
    begin
        ctl.eval         = (state_reg == S_EVAL);
        ctl.commit_reuse = resolve_go && (cmd_reg == CMD_ALLOC) && chain_w[0].fit_seen;
        ctl.commit_free  = resolve_go && (cmd_reg == CMD_FREE) && chain_w[0].base_seen
                           && chain_w[0].base_used;
        ctl.size         = size_reg;
        ctl.addr         = addr_reg;
        ctl.new_base     = heap_top_reg;
    end

    // the newest cell starts the chain with nothing seen
    assign chain_w[TABLE_ENTRIES] = '0;

    // row of entry cells, newest at the top index
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        assign entry_valid[i] = (count_reg > CNT_W'(i));
        assign append_sel[i]  = do_append && (count_reg == CNT_W'(i));

        ffba_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .entry_valid (entry_valid[i]),
            .append      (append_sel[i]),
            .chain_in    (chain_w[i+1]),
            .chain_out   (chain_w[i])
        );
    end

    // next state and result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        heap_top_next   = heap_top_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_reused_next = out_reused_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (resolve_go)
                begin
                    state_next      = in_accept ? S_EVAL : S_IDLE;
                    out_valid_next  = 1'b1;
                    out_addr_next   = '0;
                    out_reused_next = 1'b0;
                    out_status_next = ST_OK;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (chain_w[0].fit_seen)
                        begin
                            out_addr_next   = chain_w[0].fit_addr;
                            out_reused_next = 1'b1;
                        end
                        else if (table_full)
                        begin
                            out_status_next = ST_TABLE_FULL;
                        end
                        else if (over_limit)
                        begin
                            out_status_next = ST_HEAP_LIMIT;
                        end
                        else
                        begin
                            out_addr_next = heap_top_reg;
                            count_next    = count_reg + 1'b1;
                            heap_top_next = new_top[ADDR_W-1:0];
                        end
                    end
                    else
                    begin
                        if (!chain_w[0].base_seen)
                        begin
                            out_status_next = ST_UNKNOWN;
                        end
                        else if (!chain_w[0].base_used)
                        begin
                            out_status_next = ST_DOUBLE_FREE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // heap_start reloads the top while the table is empty
        if (cfg_we && (cfg_index == REG_HEAP_START) && (count_reg == '0))
        begin
            heap_top_next = cfg_data;
        end
    end

    // state, counters and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            heap_top_reg   <= '0;
            heap_start_reg <= '0;
            heap_end_reg   <= '1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            heap_top_reg  <= heap_top_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_HEAP_START))
            begin
                heap_start_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_HEAP_END))
            begin
                heap_end_reg <= cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= cmd;
            size_reg <= req_size;
            addr_reg <= req_addr;
        end
        out_addr_reg   <= out_addr_next;
        out_reused_reg <= out_reused_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign block_addr = out_addr_reg;
    assign reused     = out_reused_reg;
    assign status     = out_status_reg;

endmodule

/* hdl/ffba_checker.sv */
// port-level checks for the first-fit block allocator, bound to the top level
module ffba_checker
    import ffba_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                cmd,
    input logic [SIZE_W-1:0]   req_size,
    input logic [ADDR_W-1:0]   req_addr,
    input logic                out_valid,
    input logic                out_ready,
    input logic [ADDR_W-1:0]   block_addr,
    input logic                reused,
    input logic [STATUS_W-1:0] status,
    input logic                cfg_we,
    input logic                cfg_index,
    input logic [ADDR_W-1:0]   cfg_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_addr) && $stable(reused)
                                    && $stable(status))
        else $error("result word changed while stalled");

    // a failed request grants nothing
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (block_addr == '0) && !reused)
        else $error("failed request returned an address");

    // reuse only comes with ok status
    a_reuse_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reused |-> (status == ST_OK))
        else $error("reuse flagged with error status");

    // status stays within the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_TABLE_FULL)
                      || (status == ST_HEAP_LIMIT) || (status == ST_UNKNOWN)
                      || (status == ST_DOUBLE_FREE))
        else $error("undefined status code");

    // the compare cycle after an accept takes no new request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken during compare cycle");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

/* tb/sv/tb_top.sv */
// testbench for the first-fit block allocator: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module tb_top;
    import ffba_pkg::*;

    localparam int IDLE_PCT   = 9;
    localparam int PHASE_LEN  = 100;
    localparam int NUM_PHASES = 4;
    localparam int DIR_ROWS   = 23;

    // one granted or refused request as seen on the out channel
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic                reused;
        logic [STATUS_W-1:0] st;
    } grant_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    // directed row: a request, or a register write carried in cfg_idx / cfg_val
    typedef struct packed {
        row_kind_t           kind;
        logic                cmd;
        logic [SIZE_W-1:0]   size;
        logic [ADDR_W-1:0]   addr;
        logic                cfg_idx;
        logic [ADDR_W-1:0]   cfg_val;
        logic                typed;
        logic [ADDR_W-1:0]   exp_addr;
        logic                exp_reused;
        logic [STATUS_W-1:0] exp_st;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                cmd;
    logic [SIZE_W-1:0]   req_size;
    logic [ADDR_W-1:0]   req_addr;
    logic                out_valid;
    logic                out_ready;
    logic [ADDR_W-1:0]   block_addr;
    logic                reused;
    logic [STATUS_W-1:0] status;
    logic                cfg_we;
    logic                cfg_index;
    logic [ADDR_W-1:0]   cfg_data;

    // allocator shadow state
    logic                tbl_used [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   tbl_base [TABLE_ENTRIES];
    logic [SIZE_W-1:0]   tbl_len  [TABLE_ENTRIES];
    int                  tbl_count;
    logic [ADDR_W-1:0]   top_ptr;
    logic [ADDR_W-1:0]   cfg_heap_start;
    logic [ADDR_W-1:0]   cfg_heap_end;

    grant_t pending_grants [$];
    int     err_count;
    int     res_count;
    int     req_count;
    int     cfg_count;
    int     reuse_count;
    int     status_tally [8];
    bit     quiet_run;

    // directed rows: typed results only where they are obvious
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_REQ, CMD_FREE,  24'h0,      32'h0,        REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_UNKNOWN},
        '{ROW_CFG, CMD_ALLOC, 24'h0,      32'h0,        REG_HEAP_START, 32'hFFFF_FFFF,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_ALLOC, 24'h1,      32'h0,        REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_HEAP_LIMIT},
        '{ROW_REQ, CMD_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF, REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_HEAP_LIMIT},
        '{ROW_CFG, CMD_ALLOC, 24'h0,      32'h0,        REG_HEAP_END,   32'h0,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_CFG, CMD_ALLOC, 24'h0,      32'h0,        REG_HEAP_START, 32'h0,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_ALLOC, 24'h0,      32'h0,        REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_ALLOC, 24'h1,      32'h0,        REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_HEAP_LIMIT},
        '{ROW_REQ, CMD_FREE,  24'hFF_FFFF, 32'h0,       REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_FREE,  24'h0,      32'h0,        REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_DOUBLE_FREE},
        '{ROW_REQ, CMD_ALLOC, 24'h0,      32'h0,        REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b1, ST_OK},
        '{ROW_REQ, CMD_ALLOC, 24'h0,      32'hFFFF_FFFF, REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_FREE,  24'h0,      32'h0,        REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_FREE,  24'h0,      32'h0,        REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_DOUBLE_FREE},
        '{ROW_CFG, CMD_ALLOC, 24'h0,      32'h0,        REG_HEAP_END,   32'hFFFF_FFFF,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_CFG, CMD_ALLOC, 24'h0,      32'h0,        REG_HEAP_START, 32'h0000_1000,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF, REG_HEAP_START, 32'h0,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_ALLOC, 24'h10,     32'h0,        REG_HEAP_START, 32'h0,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_FREE,  24'h0,      32'h00FF_FFFF, REG_HEAP_START, 32'h0,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_ALLOC, 24'h8,      32'h0,        REG_HEAP_START, 32'h0,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_FREE,  24'hFF_FFFF, 32'hFFFF_FFFF, REG_HEAP_START, 32'h0,
          1'b1, 32'h0,        1'b0, ST_UNKNOWN},
        '{ROW_REQ, CMD_ALLOC, 24'h0,      32'h0,        REG_HEAP_START, 32'h0,
          1'b0, 32'h0,        1'b0, ST_OK},
        '{ROW_REQ, CMD_FREE,  24'h0,      32'h00FF_FFFF, REG_HEAP_START, 32'h0,
          1'b0, 32'h0,        1'b0, ST_OK}
    };

    first_fit_block_allocator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .req_size   (req_size),
        .req_addr   (req_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .block_addr (block_addr),
        .reused     (reused),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // first-fit search, append at heap top, free by newest matching base
    function automatic grant_t predict_grant(logic c, logic [SIZE_W-1:0] sz,
                                             logic [ADDR_W-1:0] ad);
        grant_t          g;
        int              hit;
        logic [ADDR_W:0] next_top;
        g   = '0;
        hit = -1;
        if (c == CMD_ALLOC)
        begin
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                if (hit < 0 && i < tbl_count && !tbl_used[i] && tbl_len[i] >= sz)
                    hit = i;
            if (hit >= 0)
            begin
                tbl_used[hit] = 1'b1;
                g.addr        = tbl_base[hit];
                g.reused      = 1'b1;
            end
            else if (tbl_count >= TABLE_ENTRIES)
            begin
                g.st = ST_TABLE_FULL;
            end
            else
            begin
                next_top = {1'b0, top_ptr} + (ADDR_W + 1)'(sz);
                if (next_top > {1'b0, cfg_heap_end})
                begin
                    g.st = ST_HEAP_LIMIT;
                end
                else
                begin
                    tbl_used[tbl_count] = 1'b1;
                    tbl_base[tbl_count] = top_ptr;
                    tbl_len[tbl_count]  = sz;
                    tbl_count++;
                    g.addr  = top_ptr;
                    top_ptr = next_top[ADDR_W-1:0];
                end
            end
        end
        else
        begin
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                if (hit < 0 && i < tbl_count && tbl_base[i] == ad)
                    hit = i;
            if (hit < 0)
                g.st = ST_UNKNOWN;
            else if (!tbl_used[hit])
                g.st = ST_DOUBLE_FREE;
            else
                tbl_used[hit] = 1'b0;
        end
        return g;
    endfunction

    task automatic report_mismatch(string field, logic [ADDR_W-1:0] got,
                                   logic [ADDR_W-1:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 res_count, field, got, want);
        err_count++;
    endtask

    // present one word at a falling edge, hold it until taken
    task automatic drive_word(logic c, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad,
                              logic typed, grant_t typed_val);
        grant_t g;
        while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        req_size <= sz;
        req_addr <= ad;
        do @(posedge clk); while (in_ready !== 1'b1);
        g = predict_grant(c, sz, ad);
        if (typed)
            g = typed_val;
        pending_grants.push_back(g);
        req_count++;
        @(negedge clk);
    endtask

    // stop sending and wait until every outstanding word is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HEAP_START)
        begin
            cfg_heap_start = val;
            if (tbl_count == 0)
                top_ptr = val;
        end
        else
        begin
            cfg_heap_end = val;
        end
        cfg_count++;
        @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
        out_ready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);

    // scoreboard
    always @(posedge clk)
    begin : score
        grant_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_grants.size() == 0)
            begin
                report_mismatch("unexpected word, status", ADDR_W'(status), '0);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (block_addr !== want.addr)
                    report_mismatch("block_addr", block_addr, want.addr);
                if (reused !== want.reused)
                    report_mismatch("reused", ADDR_W'(reused), ADDR_W'(want.reused));
                if (status !== want.st)
                    report_mismatch("status", ADDR_W'(status), ADDR_W'(want.st));
            end
            status_tally[status]++;
            if (reused === 1'b1)
                reuse_count++;
            res_count++;
        end
    end

    // main sequence
    initial
    begin : stim
        stim_row_t         row;
        grant_t            tv;
        logic              c;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] ad;
        int                r;
        int                w;
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_ALLOC;
        req_size  = '0;
        req_addr  = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_HEAP_START;
        cfg_data  = '0;
        quiet_run = 1'b0;
        err_count = 0;
        res_count = 0;
        req_count = 0;
        cfg_count = 0;
        reuse_count = 0;
        foreach (status_tally[i]) status_tally[i] = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_base[i] = '0;
            tbl_len[i]  = '0;
        end
        tbl_count      = 0;
        cfg_heap_start = '0;
        cfg_heap_end   = '1;
        top_ptr        = '0;

        // reset
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed table
        for (int k = 0; k < DIR_ROWS; k++)
        begin
            row = dir_rows[k];
            if (row.kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(row.cfg_idx, row.cfg_val);
            end
            else
            begin
                tv = '{row.exp_addr, row.exp_reused, row.exp_st};
                drive_word(row.cmd, row.size, row.addr, row.typed, tv);
            end
        end

        // random phases, each under its own heap limits
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: write_reg(REG_HEAP_END, top_ptr + $urandom_range(256, 8192));
                1:
                begin
                    write_reg(REG_HEAP_START, $urandom);
                    write_reg(REG_HEAP_END, 32'hFFFF_FFFF);
                end
                2: write_reg(REG_HEAP_END, $urandom);
                default: write_reg(REG_HEAP_END, top_ptr);
            endcase
            quiet_run = (ph == 2);
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                // once per phase, at request 60, the sender holds off until the block is empty
                if (k == 60)
                    wait_drained();
                c  = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE;
                sz = SIZE_W'($urandom);
                ad = $urandom;
                if (c == CMD_ALLOC)
                begin
                    // mostly sizes that fit or exactly match an entry
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        sz = '0;
                    else if (r < 45)
                        sz = SIZE_W'($urandom_range(1, 64));
                    else if (r < 70 && tbl_count > 0)
                        sz = tbl_len[$urandom_range(0, tbl_count - 1)];
                    else if (r < 85)
                        sz = SIZE_W'($urandom_range(65, 4096));
                end
                else if (tbl_count > 0 && $urandom_range(0, 9) < 8)
                begin
                    // free of a known base, noise otherwise
                    ad = tbl_base[$urandom_range(0, tbl_count - 1)];
                end
                drive_word(c, sz, ad, 1'b0, '0);
            end
        end
        quiet_run = 1'b0;

        // drain and settle
        in_valid <= 1'b0;
        for (w = 0; w < 20000 && pending_grants.size() != 0; w++)
            @(negedge clk);
        if (pending_grants.size() != 0)
            report_mismatch("words never returned", ADDR_W'(pending_grants.size()), '0);
        repeat (10) @(negedge clk);

        $display("covered %0d requests and %0d register writes, %0d reuse grants",
                 req_count, cfg_count, reuse_count);
        $display("status ok %0d, table full %0d, heap limit %0d, unknown %0d, double free %0d",
                 status_tally[ST_OK], status_tally[ST_TABLE_FULL],
                 status_tally[ST_HEAP_LIMIT], status_tally[ST_UNKNOWN],
                 status_tally[ST_DOUBLE_FREE]);
        if (err_count == 0)
            $display("first_fit_block_allocator verification clean");
        else
            $display("first_fit_block_allocator verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(5_000_000);
        $display("first_fit_block_allocator verification failed");
        $finish;
    end

endmodule
